// ===== design/longest_prefix_route_table_macros.svh =====
// Assertion macros for the longest prefix route table.
// Included by the modules that carry concurrent checks.
`ifndef LONGEST_PREFIX_ROUTE_TABLE_MACROS_SVH
`define LONGEST_PREFIX_ROUTE_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define LPRT_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error("lprt check failed");
`define LPRT_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) else $error("lprt check failed");
`else
`define LPRT_ASSERT(lbl, clk_s, rst_s, prop)
`define LPRT_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif
`endif

// ===== design/lprt_pkg.sv =====
// Shared types and constants of the longest prefix route table.
// No dependencies.
package lprt_pkg;
  localparam int TableDepth = 64;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  // entry word: direct, hop, mask, dest
  localparam int EntryW = 97;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0, FUNC_DEL = 2'd1, FUNC_LOOKUP = 2'd2, FUNC_SPARE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_ADDED = 3'd0, ST_FULL = 3'd1, ST_DELETED = 3'd2, ST_REFUSED = 3'd3,
    ST_NOT_FOUND = 3'd4, ST_ROUTED = 3'd5, ST_DIRECT = 3'd6, ST_NO_ROUTE = 3'd7
  } status_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] address;
    logic [31:0] prefix_mask;
    logic [31:0] next_hop_addr;
    logic        is_direct;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] hop;
    logic [6:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic        direct;
    logic [31:0] hop;
    logic [31:0] mask;
    logic [31:0] dest;
  } entry_t;

  // memory port request from the sequencer
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
    logic [IdxW-1:0] raddr;
  } mem_ctl_t;
endpackage

// ===== design/lprt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lprt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/lprt_seq.sv =====
// Sequencer: walks the table through the entry RAM for add, delete and lookup.
// Depends on lprt_pkg and the assertion macro header.
`include "longest_prefix_route_table_macros.svh"
module lprt_seq import lprt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  req_t     req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output rsp_t     rsp,
  output mem_ctl_t mem_ctl,
  input  entry_t   rdata
);
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,  // read entry idx, compare when data is back
    S_SHIFTU = 7'b0000100,  // add: move entries up, top down
    S_SHIFTD = 7'b0001000,  // delete: move entries down
    S_WRITE  = 7'b0010000,
    S_RESP   = 7'b0100000,
    S_WAIT   = 7'b1000000
  } state_t;

  state_t          state;
  req_t            op;
  logic [CntW-1:0] count;
  logic [CntW-1:0] idx;      // scan: entry whose data arrives this cycle; shift: entry written
  logic            rd_pend;  // read data is valid (for idx in scan, for the neighbour of idx in shift)
  logic [2:0]      st;
  logic [31:0]     hop_r;
  rsp_t            out_r;
  logic            out_v;
  logic [CntW-1:0] cnt_ext;
  logic            hit;
  logic            in_range;

  assign req_ready = (state == S_IDLE) && !out_v;
  assign rsp_valid = out_v;
  assign rsp = out_r;
  assign in_range = idx < count;

  always_comb begin
    case (op.func)
      FUNC_ADD: hit = rdata.mask < op.prefix_mask;
      FUNC_DEL: hit = rdata.dest == op.address;
      default:  hit = (rdata.mask & op.address) == (rdata.mask & rdata.dest);
    endcase
  end

  always_comb begin
    mem_ctl = '0;
    mem_ctl.raddr = idx[IdxW-1:0];
    case (state)
      S_SCAN: begin
        mem_ctl.raddr = rd_pend ? IdxW'(idx + 1'b1) : idx[IdxW-1:0];
      end
      S_SHIFTU: begin
        // data of idx-1 is back: write it to idx, read idx-2
        mem_ctl.we = rd_pend;
        mem_ctl.waddr = idx[IdxW-1:0];
        mem_ctl.wdata = rdata;
        mem_ctl.raddr = rd_pend ? IdxW'(idx - 2'd2) : IdxW'(idx - 1'b1);
      end
      S_SHIFTD: begin
        // data of idx+1 is back: write it to idx, read idx+2
        mem_ctl.we = rd_pend;
        mem_ctl.waddr = idx[IdxW-1:0];
        mem_ctl.wdata = rdata;
        mem_ctl.raddr = rd_pend ? IdxW'(idx + 2'd2) : IdxW'(idx + 1'b1);
      end
      S_WRITE: begin
        mem_ctl.we = 1'b1;
        mem_ctl.waddr = idx[IdxW-1:0];
        mem_ctl.wdata = '{direct: op.is_direct, hop: op.next_hop_addr,
                          mask: op.prefix_mask, dest: op.address};
      end
      default: ;
    endcase
  end

  assign cnt_ext = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_v <= 1'b0;
      rd_pend <= 1'b0;
      idx <= '0;
    end else begin
      if (out_v && rsp_ready) out_v <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            op <= req;
            idx <= '0;
            rd_pend <= 1'b0;
            hop_r <= '0;
            if (req.func == FUNC_ADD && count >= CntW'(TableDepth)) begin
              st <= ST_FULL;
              state <= S_RESP;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!rd_pend) begin
            // first read issued at idx
            if (!in_range) begin
              case (op.func)
                FUNC_ADD: state <= S_WRITE;
                FUNC_DEL: begin st <= ST_NOT_FOUND; state <= S_RESP; end
                default:  begin st <= ST_NO_ROUTE; state <= S_RESP; end
              endcase
            end else begin
              rd_pend <= 1'b1;
            end
          end else if (hit) begin
            rd_pend <= 1'b0;
            case (op.func)
              FUNC_ADD: begin
                idx <= count;
                st <= '0;
                state <= (idx == count) ? S_WRITE : S_SHIFTU;
                hop_r <= {{(32-CntW){1'b0}}, idx};  // insert position
              end
              FUNC_DEL: begin
                if (rdata.direct) begin
                  st <= ST_REFUSED;
                  state <= S_RESP;
                end else begin
                  state <= S_SHIFTD;
                end
              end
              default: begin
                st <= rdata.direct ? ST_DIRECT : ST_ROUTED;
                hop_r <= rdata.direct ? 32'd0 : rdata.hop;
                state <= S_RESP;
              end
            endcase
          end else begin
            idx <= idx + 1'b1;
            if (idx + 1'b1 >= count) begin
              rd_pend <= 1'b0;
              case (op.func)
                FUNC_ADD: state <= S_WRITE;
                FUNC_DEL: begin st <= ST_NOT_FOUND; state <= S_RESP; end
                default:  begin st <= ST_NO_ROUTE; state <= S_RESP; end
              endcase
            end
          end
        end
        S_SHIFTU: begin
          // hop_r holds insert position
          if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            idx <= idx - 1'b1;
            if (idx - 1'b1 == hop_r[CntW-1:0]) begin
              rd_pend <= 1'b0;
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          st <= ST_ADDED;
          count <= count + 1'b1;
          state <= S_RESP;
        end
        S_SHIFTD: begin
          if (idx + 1'b1 >= count) begin
            count <= count - 1'b1;
            st <= ST_DELETED;
            rd_pend <= 1'b0;
            state <= S_RESP;
          end else if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_RESP: begin
          out_r <= '{status: st, hop: hop_r & {32{st == ST_ROUTED}},
                     entry_count: 7'(cnt_ext)};
          out_v <= 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (!out_v || rsp_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LPRT_ASSERT(a_count_range, clk, rst, count <= CntW'(TableDepth))
  `LPRT_ASSERT(a_no_accept_busy, clk, rst, (state != S_IDLE) |-> !req_ready)
  `LPRT_ASSERT(a_full_no_grow, clk, rst,
               (state == S_WRITE) |-> (count < CntW'(TableDepth)))
  `LPRT_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> (state == S_IDLE && !out_v))
endmodule

// ===== design/longest_prefix_route_table.sv =====
// Top level of the longest prefix route table: sequencer plus entry RAM.
// Depends on lprt_pkg, lprt_ram and lprt_seq.
//
// Usage: send an item on req (valid/ready) with func add, delete or lookup.
// Exactly one result item comes back on rsp (valid/ready): status, hop and
// entry count after the operation.
// Entries live in one RAM word each (dest, mask, hop, direct), kept sorted
// longest mask first in positions 0 .. count-1. The sequencer reads one RAM
// word per cycle, with registered read data, in these steps:
//   lookup / delete: scan from position 0 up to the hit or the entry count,
//   add: scan to the insert point, then shift the entries from it up by one,
//   delete: after the scan, shift the entries above the hit down by one,
// then write a new entry or close a delete, and load the result into the
// output register. One item is in work at a time, and the next can be taken
// in the cycle after the result has left.
// Reset clears the entry count, not the RAM; words past the count go unused.
// A stalled receiver holds the result in the output register, and no new
// item is taken until it has left.
module longest_prefix_route_table import lprt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);
  mem_ctl_t mem_ctl;
  entry_t   rdata;
  logic [EntryW-1:0] rdata_w;

  lprt_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
    .clk   (clk),
    .we    (mem_ctl.we),
    .waddr (mem_ctl.waddr),
    .wdata (mem_ctl.wdata),
    .raddr (mem_ctl.raddr),
    .rdata (rdata_w)
  );
  assign rdata = rdata_w;

  lprt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .mem_ctl   (mem_ctl),
    .rdata     (rdata)
  );
endmodule
